[hdl/quadrature_edge_sampler_fifo_macros.svh]
// assertion macros for the quadrature edge sampler
`ifndef QUADRATURE_EDGE_SAMPLER_FIFO_MACROS_SVH
`define QUADRATURE_EDGE_SAMPLER_FIFO_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define QESF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define QESF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/qesf_pkg.sv]
// shared types, constants and decode helpers for the quadrature edge sampler
package qesf_pkg;

  // event ring
  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // statistics counters
  localparam int NUM_STATS = 6;
  localparam logic [2:0] STAT_SAMPLES  = 3'd0;
  localparam logic [2:0] STAT_FORWARD  = 3'd1;
  localparam logic [2:0] STAT_REVERSE  = 3'd2;
  localparam logic [2:0] STAT_INVALID  = 3'd3;
  localparam logic [2:0] STAT_GLITCH   = 3'd4;
  localparam logic [2:0] STAT_OVERFLOW = 3'd5;

  // step codes, two's complement
  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_FWD  = 2'b01;
  localparam logic [1:0] STEP_REV  = 2'b11;

  // limits and reset values
  localparam logic [15:0] GAP_MAX           = 16'hFFFF;
  localparam logic [31:0] CNT_MAX           = 32'hFFFF_FFFF;
  localparam logic [15:0] GLITCH_WINDOW_RST = 16'd4;

  // configuration register indexes
  localparam logic CFG_GLITCH_WINDOW = 1'b0;
  localparam logic CFG_DIR_INVERT    = 1'b1;

  typedef enum logic [2:0] {
    ACT_SAMPLE    = 3'd0,
    ACT_POP       = 3'd1,
    ACT_TAKE_FLAG = 3'd2,
    ACT_READ_STAT = 3'd3,
    ACT_RESTART   = 3'd4
  } action_t;

  // one stored edge
  typedef struct packed {
    logic [31:0] tick;
    logic [15:0] gap;
    logic [1:0]  from;
    logic [1:0]  to;
    logic [1:0]  step;
  } event_rec_t;

  // classification of one sample against the accepted state
  typedef struct packed {
    logic        changed;
    logic        glitch;
    logic        accept;
    logic [1:0]  step;
    logic [15:0] gap_sat;
  } edge_info_t;

  // position of a line state in forward gray order 00,01,11,10
  function automatic logic [1:0] gray_pos(input logic [1:0] lines);
    logic [1:0] pos;
    case (lines)
      2'b00:   pos = 2'd0;
      2'b01:   pos = 2'd1;
      2'b11:   pos = 2'd2;
      2'b10:   pos = 2'd3;
      default: pos = 2'd0;
    endcase
    return pos;
  endfunction

  // wrap-around pointer increment
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

[hdl/qesf_edge_filter.sv]
// gray decode, gap measurement and glitch classification of one sample
module qesf_edge_filter import qesf_pkg::*; (
  input  logic [1:0]  accepted_lines,
  input  logic [31:0] last_edge,
  input  logic [1:0]  ab_lines,
  input  logic [31:0] tick_count,
  input  logic [15:0] glitch_window,
  input  logic        direction_invert,
  output edge_info_t  info
);

  logic [1:0]  pos_delta;
  logic [1:0]  pos_delta_dir;
  logic [31:0] gap;

  // distance along gray order, mirrored when direction is inverted
  assign pos_delta     = gray_pos(ab_lines) - gray_pos(accepted_lines);
  assign pos_delta_dir = direction_invert ? (2'd0 - pos_delta) : pos_delta;
  assign gap           = tick_count - last_edge;

  always_comb begin
    case (pos_delta_dir)
      2'd1:    info.step = STEP_FWD;
      2'd3:    info.step = STEP_REV;
      default: info.step = STEP_NONE;
    endcase
    info.changed = (ab_lines != accepted_lines);
    // non-forward change too soon after the last edge is bounce
    info.glitch  = info.changed && (info.step != STEP_FWD) && (gap < {16'd0, glitch_window});
    info.accept  = info.changed && !info.glitch;
    info.gap_sat = (gap > {16'd0, GAP_MAX}) ? GAP_MAX : gap[15:0];
  end

endmodule

[hdl/qesf_ring.sv]
// event ring: pointers, storage and registered head entry
module qesf_ring import qesf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       restart,
  input  logic       push,
  input  event_rec_t push_rec,
  input  logic       pop,
  output logic       empty,
  output logic       full,
  output event_rec_t head
);

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  event_rec_t       mem [RING_DEPTH];

  // one slot stays free to tell full from empty
  assign empty = (rd_ptr == wr_ptr);
  assign full  = (ptr_inc(wr_ptr) == rd_ptr);

  // pointer next values
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (restart) begin
      wr_ptr_next = '0;
      rd_ptr_next = '0;
    end else begin
      if (push) wr_ptr_next = ptr_inc(wr_ptr);
      if (pop)  rd_ptr_next = ptr_inc(rd_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  // storage write and head read, write data forwarded into an empty ring
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
    if (push && (wr_ptr == rd_ptr_next)) begin
      head <= push_rec;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

endmodule

[hdl/quadrature_edge_sampler_fifo.sv]
// top level: input stage, state update, statistics and result register
//
// Quadrature edge sampler with glitch filter and a 32-entry event ring.
// Input transactions arrive on s_axis: tuser carries the action code,
// tdata the line levels, tick stamp and statistics index. Every input
// transaction yields exactly one result transaction on m_axis carrying
// the popped event, overflow flag, statistic and current line status.
// Configuration (glitch window, direction invert) is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the block is
// idle; the block does not enforce this. A result passes from the input
// register, loaded at the accepting edge, to the result register, loaded
// when the input stage advances. Throughput: one transaction per cycle
// while m_axis does not stall; decode, gap compare, counter update and
// ring write all happen in the single step between the two registers.
// The ring holds 31 events; the head entry is read ahead into a register.
// Reset: ring empty, not seeded, counters zero, glitch window 4.
// When m_axis stalls the result register holds, and s_axis keeps taking
// one more transaction into the input register before tready drops.
module quadrature_edge_sampler_fifo import qesf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  // input channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // ab_lines[1:0], tick_count[33:2], stat_index[36:34]
  input  logic [2:0]   s_axis_tuser,  // action[2:0]
  // result channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // popped[0], event_tick[32:1], event_gap[48:33],
                                      // event_from[50:49], event_to[52:51],
                                      // event_step[54:53], overflow_seen[55],
                                      // line_state[57:56], seeded[58],
                                      // last_edge_tick[90:59], stat_value[122:91]
);

`include "quadrature_edge_sampler_fifo_macros.svh"

  // configuration registers
  logic [15:0] glitch_window;
  logic        direction_invert;

  // input stage
  logic        in_valid;
  logic [2:0]  in_action;
  logic [1:0]  in_ab;
  logic [31:0] in_tick;
  logic [2:0]  in_sidx;
  logic        advance;

  // block state
  logic [1:0]  accepted_lines, accepted_lines_next;
  logic        seeded, seeded_next;
  logic [31:0] last_edge, last_edge_next;
  logic        sticky_overflow, sticky_overflow_next;
  logic [31:0] stat_cnt      [NUM_STATS];
  logic [31:0] stat_cnt_next [NUM_STATS];

  // ring control
  logic        ring_restart, ring_push, ring_pop, ring_empty, ring_full;
  logic        ovf_hit;
  event_rec_t  push_rec, head;
  edge_info_t  info;

  // result values
  logic        res_popped, res_ovf;
  event_rec_t  res_event;
  logic [31:0] res_stat;

  // result register
  logic        out_valid;
  logic        out_popped, out_ovf, out_seeded;
  event_rec_t  out_event;
  logic [1:0]  out_lines;
  logic [31:0] out_last, out_stat;

  // handshake: the input stage moves on when the result register is free
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_window    <= GLITCH_WINDOW_RST;
      direction_invert <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GLITCH_WINDOW: glitch_window    <= cfg_data;
        CFG_DIR_INVERT:    direction_invert <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser;
      in_ab     <= s_axis_tdata[1:0];
      in_tick   <= s_axis_tdata[33:2];
      in_sidx   <= s_axis_tdata[36:34];
    end
  end

  qesf_edge_filter u_edge_filter (
    .accepted_lines   (accepted_lines),
    .last_edge        (last_edge),
    .ab_lines         (in_ab),
    .tick_count       (in_tick),
    .glitch_window    (glitch_window),
    .direction_invert (direction_invert),
    .info             (info)
  );

  assign push_rec = '{tick: in_tick, gap: info.gap_sat, from: accepted_lines,
                      to: in_ab, step: info.step};

  qesf_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .restart  (ring_restart),
    .push     (ring_push),
    .push_rec (push_rec),
    .pop      (ring_pop),
    .empty    (ring_empty),
    .full     (ring_full),
    .head     (head)
  );

  // action execution and next state
  always_comb begin
    accepted_lines_next  = accepted_lines;
    seeded_next          = seeded;
    last_edge_next       = last_edge;
    sticky_overflow_next = sticky_overflow;
    for (int i = 0; i < NUM_STATS; i++) stat_cnt_next[i] = stat_cnt[i];
    ring_restart = 1'b0;
    ring_push    = 1'b0;
    ring_pop     = 1'b0;
    ovf_hit      = 1'b0;
    res_popped   = 1'b0;
    res_event    = '0;
    res_ovf      = 1'b0;
    res_stat     = '0;
    if (advance) begin
      case (action_t'(in_action))
        ACT_SAMPLE: begin
          stat_cnt_next[STAT_SAMPLES] = stat_cnt[STAT_SAMPLES] + 32'd1;
          if (!seeded) begin
            // first sample seeds the state
            accepted_lines_next = in_ab;
            last_edge_next      = in_tick;
            seeded_next         = 1'b1;
          end else if (info.glitch) begin
            if (stat_cnt[STAT_GLITCH] != CNT_MAX) begin
              stat_cnt_next[STAT_GLITCH] = stat_cnt[STAT_GLITCH] + 32'd1;
            end
          end else if (info.accept) begin
            accepted_lines_next = in_ab;
            last_edge_next      = in_tick;
            case (info.step)
              STEP_FWD: stat_cnt_next[STAT_FORWARD] = stat_cnt[STAT_FORWARD] + 32'd1;
              STEP_REV: stat_cnt_next[STAT_REVERSE] = stat_cnt[STAT_REVERSE] + 32'd1;
              default:  stat_cnt_next[STAT_INVALID] = stat_cnt[STAT_INVALID] + 32'd1;
            endcase
            if (ring_full) begin
              ovf_hit                      = 1'b1;
              stat_cnt_next[STAT_OVERFLOW] = stat_cnt[STAT_OVERFLOW] + 32'd1;
              sticky_overflow_next         = 1'b1;
            end else begin
              ring_push = 1'b1;
            end
          end
        end
        ACT_POP: begin
          if (!ring_empty) begin
            ring_pop   = 1'b1;
            res_popped = 1'b1;
            res_event  = head;
          end
        end
        ACT_TAKE_FLAG: begin
          res_ovf              = sticky_overflow;
          sticky_overflow_next = 1'b0;
        end
        ACT_READ_STAT: begin
          if (in_sidx < 3'(NUM_STATS)) res_stat = stat_cnt[in_sidx];
        end
        ACT_RESTART: begin
          ring_restart         = 1'b1;
          accepted_lines_next  = 2'b00;
          seeded_next          = 1'b0;
          last_edge_next       = in_tick;
          sticky_overflow_next = 1'b0;
          for (int i = 0; i < NUM_STATS; i++) stat_cnt_next[i] = '0;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_lines  <= 2'b00;
      seeded          <= 1'b0;
      last_edge       <= '0;
      sticky_overflow <= 1'b0;
      for (int i = 0; i < NUM_STATS; i++) stat_cnt[i] <= '0;
    end else begin
      accepted_lines  <= accepted_lines_next;
      seeded          <= seeded_next;
      last_edge       <= last_edge_next;
      sticky_overflow <= sticky_overflow_next;
      for (int i = 0; i < NUM_STATS; i++) stat_cnt[i] <= stat_cnt_next[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_popped <= res_popped;
      out_event  <= res_event;
      out_ovf    <= res_ovf;
      out_lines  <= accepted_lines_next;
      out_seeded <= seeded_next;
      out_last   <= last_edge_next;
      out_stat   <= res_stat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_stat, out_last, out_seeded, out_lines, out_ovf,
                          out_event.step, out_event.to, out_event.from,
                          out_event.gap, out_event.tick, out_popped};

  // checks
  `QESF_ASSERT_IMP(a_unseeded_ring_empty, !seeded, ring_empty,
                   "ring holds events while not seeded")
  `QESF_ASSERT_NXT(a_pop_returns_event,
                   advance && (in_action == ACT_POP) && !ring_empty,
                   out_valid && out_popped, "pop on a non-empty ring gave no event")
  `QESF_ASSERT_NXT(a_glitch_count_rises, !(advance && (in_action == ACT_RESTART)),
                   stat_cnt[STAT_GLITCH] >= $past(stat_cnt[STAT_GLITCH]),
                   "glitch count fell without a restart")
  `QESF_ASSERT_NXT(a_overflow_sets_flag, ovf_hit, sticky_overflow && !ring_empty,
                   "edge dropped on a full ring without raising the flag")

endmodule

[dv/quadrature_edge_sampler_fifo_checker.sv]
// checker for the quadrature edge sampler: decode prediction and result comparison
module quadrature_edge_sampler_fifo_checker import qesf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // ab_lines[1:0], tick_count[33:2], stat_index[36:34]
  input  logic [2:0]   s_axis_tuser,  // action[2:0]
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,  // popped[0], event_tick[32:1], event_gap[48:33],
                                      // event_from[50:49], event_to[52:51],
                                      // event_step[54:53], overflow_seen[55],
                                      // line_state[57:56], seeded[58],
                                      // last_edge_tick[90:59], stat_value[122:91]
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // result word, first member in the top bits so it casts straight from tdata
  typedef struct packed {
    logic [31:0] stat_value;
    logic [31:0] last_edge_tick;
    logic        seeded;
    logic [1:0]  line_state;
    logic        overflow_seen;
    logic [1:0]  event_step;
    logic [1:0]  event_to;
    logic [1:0]  event_from;
    logic [15:0] event_gap;
    logic [31:0] event_tick;
    logic        popped;
  } status_word_t;

  // settings and decoder state as the block should hold them
  logic [15:0]      glitch_win;
  logic             dir_inv;
  logic [1:0]       held_lines;
  logic             is_seeded;
  logic [31:0]      edge_stamp;
  logic             drop_mark;
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  event_rec_t       edge_ring [RING_DEPTH];
  logic [31:0]      counters [NUM_STATS];

  status_word_t status_due [$];
  int           mismatch_count = 0;
  int           due_count = 0;
  int unsigned  result_no = 0;

  assign errors  = mismatch_count;
  assign pending = due_count;

  // next state along the forward gray walk
  function automatic logic [1:0] gray_succ(input logic [1:0] s);
    case (s)
      2'b00:   return 2'b01;
      2'b01:   return 2'b11;
      2'b11:   return 2'b10;
      default: return 2'b00;
    endcase
  endfunction

  function automatic logic [1:0] step_of(input logic [1:0] from, input logic [1:0] to,
                                         input logic invert);
    logic [1:0] code;
    if (to == gray_succ(from)) code = STEP_FWD;
    else if (from == gray_succ(to)) code = STEP_REV;
    else code = STEP_NONE;
    if (invert && code != STEP_NONE) code = (code == STEP_FWD) ? STEP_REV : STEP_FWD;
    return code;
  endfunction

  function automatic logic [PTR_W-1:0] ring_after(input logic [PTR_W-1:0] p);
    return (int'(p) == RING_DEPTH - 1) ? '0 : PTR_W'(int'(p) + 1);
  endfunction

  task automatic clear_decoder(input logic [31:0] tick);
    held_lines = 2'b00;
    is_seeded  = 1'b0;
    edge_stamp = tick;
    drop_mark  = 1'b0;
    head_ptr   = '0;
    tail_ptr   = '0;
    for (int i = 0; i < NUM_STATS; i++) counters[i] = '0;
  endtask

  // one line sample: seed, ignore, filter as bounce or log the edge
  task automatic take_sample(input logic [1:0] ab, input logic [31:0] tick);
    logic [1:0]  step;
    logic [31:0] gap;
    counters[STAT_SAMPLES] += 1;
    if (!is_seeded) begin
      held_lines = ab;
      edge_stamp = tick;
      is_seeded  = 1'b1;
    end else if (ab != held_lines) begin
      step = step_of(held_lines, ab, dir_inv);
      gap  = tick - edge_stamp;
      if (step != STEP_FWD && gap < 32'(glitch_win)) begin
        if (counters[STAT_GLITCH] != CNT_MAX) counters[STAT_GLITCH] += 1;
      end else begin
        if (step == STEP_FWD) counters[STAT_FORWARD] += 1;
        else if (step == STEP_REV) counters[STAT_REVERSE] += 1;
        else counters[STAT_INVALID] += 1;
        if (ring_after(tail_ptr) == head_ptr) begin
          counters[STAT_OVERFLOW] += 1;
          drop_mark = 1'b1;
        end else begin
          edge_ring[tail_ptr].tick = tick;
          edge_ring[tail_ptr].gap  = (gap > 32'(GAP_MAX)) ? GAP_MAX : gap[15:0];
          edge_ring[tail_ptr].from = held_lines;
          edge_ring[tail_ptr].to   = ab;
          edge_ring[tail_ptr].step = step;
          tail_ptr = ring_after(tail_ptr);
        end
        held_lines = ab;
        edge_stamp = tick;
      end
    end
  endtask

  // works out the result word of one input transaction
  task automatic decode_transaction(input logic [2:0] act, input logic [39:0] data,
                                    output status_word_t res);
    logic [1:0]  ab;
    logic [31:0] tick;
    logic [2:0]  sidx;
    ab   = data[1:0];
    tick = data[33:2];
    sidx = data[36:34];
    res  = '0;
    case (act)
      ACT_SAMPLE: take_sample(ab, tick);
      ACT_POP: begin
        if (head_ptr != tail_ptr) begin
          res.popped     = 1'b1;
          res.event_tick = edge_ring[head_ptr].tick;
          res.event_gap  = edge_ring[head_ptr].gap;
          res.event_from = edge_ring[head_ptr].from;
          res.event_to   = edge_ring[head_ptr].to;
          res.event_step = edge_ring[head_ptr].step;
          head_ptr = ring_after(head_ptr);
        end
      end
      ACT_TAKE_FLAG: begin
        res.overflow_seen = drop_mark;
        drop_mark         = 1'b0;
      end
      ACT_READ_STAT: begin
        if (int'(sidx) < NUM_STATS) res.stat_value = counters[sidx];
      end
      ACT_RESTART: clear_decoder(tick);
      default: ;
    endcase
    res.line_state     = held_lines;
    res.seeded         = is_seeded;
    res.last_edge_tick = edge_stamp;
  endtask

  task automatic report(input string msg);
    mismatch_count++;
    $display("[%0t] result %0d: %s", $realtime, result_no, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s is %h, %h due", name, got, want));
  endtask

  task automatic compare_status(input status_word_t got, input status_word_t want);
    check_field("popped", 32'(got.popped), 32'(want.popped));
    check_field("event_tick", got.event_tick, want.event_tick);
    check_field("event_gap", 32'(got.event_gap), 32'(want.event_gap));
    check_field("event_from", 32'(got.event_from), 32'(want.event_from));
    check_field("event_to", 32'(got.event_to), 32'(want.event_to));
    check_field("event_step", 32'(got.event_step), 32'(want.event_step));
    check_field("overflow_seen", 32'(got.overflow_seen), 32'(want.overflow_seen));
    check_field("line_state", 32'(got.line_state), 32'(want.line_state));
    check_field("seeded", 32'(got.seeded), 32'(want.seeded));
    check_field("last_edge_tick", got.last_edge_tick, want.last_edge_tick);
    check_field("stat_value", got.stat_value, want.stat_value);
  endtask

  // watch both channels and the configuration port
  always @(posedge clk) begin
    status_word_t got_word;
    status_word_t due_word;
    if (rst) begin
      glitch_win = GLITCH_WINDOW_RST;
      dir_inv    = 1'b0;
      clear_decoder('0);
      status_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GLITCH_WINDOW) glitch_win = cfg_data;
        else dir_inv = cfg_data[0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_word = status_word_t'(m_axis_tdata[122:0]);
        if (status_due.size() == 0) begin
          report("result with no input transaction waiting");
        end else begin
          due_word = status_due.pop_front();
          compare_status(got_word, due_word);
        end
        result_no++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_transaction(s_axis_tuser, s_axis_tdata, due_word);
        status_due.push_back(due_word);
      end
    end
    due_count <= status_due.size();
  end

endmodule

[dv/quadrature_edge_sampler_fifo_tb.sv]
// testbench top: clock, reset, stimulus, result sink and verdict
module quadrature_edge_sampler_fifo_tb import qesf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ACT_SPARE_LO = 3'd5;
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
  localparam logic [2:0]  STAT_SPARE   = 3'd7;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int          NUM_PHASES   = 7;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CFG_GLITCH_WINDOW;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;  // ab_lines[1:0], tick_count[33:2], stat_index[36:34]
  logic [2:0]   s_axis_tuser = '0;  // action[2:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;       // popped[0], event_tick[32:1], event_gap[48:33],
                                    // event_from[50:49], event_to[52:51],
                                    // event_step[54:53], overflow_seen[55],
                                    // line_state[57:56], seeded[58],
                                    // last_edge_tick[90:59], stat_value[122:91]
  int errors;
  int pending;

  // per-phase glitch window, direction and share of pops
  int unsigned phase_win [NUM_PHASES] = '{0, 65535, 16, 1, 65535, 4000, 7};
  logic        phase_inv [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
  int unsigned phase_pop [NUM_PHASES] = '{8, 20, 30, 12, 25, 10, 18};

  bit          send_calm = 1'b0;
  logic [1:0]  walk_lines = 2'b00;
  logic [31:0] tick_now = '0;

  quadrature_edge_sampler_fifo dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  quadrature_edge_sampler_fifo_checker edge_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] tick_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 8);
    if (r < 85) return $urandom_range(0, 300);
    if (r < 95) return $urandom_range(0, 131072);
    return $urandom;
  endfunction

  // one input transaction, then an optional pause
  task automatic offer(input logic [2:0] act, input logic [1:0] ab, input logic [31:0] tick,
                       input logic [2:0] sidx);
    int unsigned pause;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {3'b000, sidx, tick, ab};
    do @(posedge clk); while (!s_axis_tready);
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    pause = send_calm ? 0 : gap_len();
    if (pause != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  // let every outstanding result come back before touching the registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] window, input logic invert);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GLITCH_WINDOW;
    cfg_data  <= window;
    @(posedge clk);
    cfg_index <= CFG_DIR_INVERT;
    cfg_data  <= {15'd0, invert};
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // mostly gray walks with random timing, plus pops, reads and noise
  task automatic random_phase(input int unsigned count, input int unsigned pop_pct);
    int unsigned r;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) walk_lines ^= 2'(1 << $urandom_range(0, 1));
        else if (pick < 17) walk_lines = 2'($urandom);
        tick_now += tick_delta();
        offer(ACT_SAMPLE, walk_lines, tick_now, 3'($urandom));
      end else if (r < 62 + pop_pct) begin
        offer(ACT_POP, 2'($urandom), $urandom, 3'($urandom));
      end else if (r < 98) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) offer(ACT_RESTART, 2'($urandom), tick_now, 3'($urandom));
        else if (pick < 35) offer(ACT_TAKE_FLAG, 2'($urandom), $urandom, 3'($urandom));
        else offer(ACT_READ_STAT, 2'($urandom), $urandom, 3'($urandom_range(0, 7)));
      end else begin
        offer(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), 2'($urandom), $urandom,
              3'($urandom));
      end
    end
  endtask

  // result sink: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned taken;
    bit          calm;
    bit          held;
    stall_left = 0;
    taken      = 0;
    calm       = 1'b0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (!held && taken >= 700) begin
        held       = 1'b1;
        stall_left = 400;
      end
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // give up when nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("quadrature_edge_sampler_fifo_tb: errors");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    load_settings(GLITCH_WINDOW_RST, 1'b0);

    // pop on an empty ring, out-of-range stat, flag before anything happened
    offer(ACT_POP, 2'b00, 32'h0, STAT_SAMPLES);
    offer(ACT_READ_STAT, 2'b11, 32'hFFFF_FFFF, STAT_SPARE);
    offer(ACT_TAKE_FLAG, 2'b00, 32'h0, STAT_SAMPLES);
    // seed near the top of the tick range, then forward inside the window
    offer(ACT_SAMPLE, 2'b11, 32'hFFFF_FFF0, STAT_SAMPLES);
    offer(ACT_SAMPLE, 2'b10, 32'hFFFF_FFF2, STAT_SAMPLES);
    // reverse bounce, then a double change across the tick wrap
    offer(ACT_SAMPLE, 2'b11, 32'hFFFF_FFF3, STAT_SAMPLES);
    offer(ACT_SAMPLE, 2'b01, 32'h0000_0010, STAT_SAMPLES);
    // reverse with a gap that saturates, then no change at the top tick
    offer(ACT_SAMPLE, 2'b00, 32'h0002_0000, STAT_SAMPLES);
    offer(ACT_SAMPLE, 2'b00, 32'hFFFF_FFFF, STAT_SAMPLES);
    // drain the ring and run one pop past empty
    repeat (4) offer(ACT_POP, 2'b00, 32'h0, STAT_SAMPLES);
    offer(ACT_READ_STAT, 2'b00, 32'h0, STAT_SAMPLES);
    offer(ACT_READ_STAT, 2'b00, 32'h0, STAT_GLITCH);
    offer(ACT_READ_STAT, 2'b00, 32'h0, STAT_OVERFLOW + 3'd1);
    // codes past restart change nothing
    offer(ACT_SPARE_LO, 2'b11, 32'hFFFF_FFFF, STAT_SPARE);
    offer(ACT_SPARE_HI, 2'b00, 32'h0, STAT_SAMPLES);
    // restart, then a fresh seed, a bounce and a forward step
    offer(ACT_RESTART, 2'b11, 32'hFFFF_FFFF, STAT_SAMPLES);
    offer(ACT_READ_STAT, 2'b00, 32'h0, STAT_FORWARD);
    offer(ACT_SAMPLE, 2'b00, 32'h0, STAT_SAMPLES);
    offer(ACT_SAMPLE, 2'b11, 32'h0, STAT_SAMPLES);
    offer(ACT_SAMPLE, 2'b01, 32'h5, STAT_SAMPLES);
    offer(ACT_TAKE_FLAG, 2'b00, 32'h0, STAT_SAMPLES);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_settings(16'(phase_win[p]), phase_inv[p]);
      random_phase(250, phase_pop[p]);
      drain();
    end
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("quadrature_edge_sampler_fifo_tb: clean");
    end else begin
      $display("quadrature_edge_sampler_fifo_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/qesf_pkg.sv
hdl/qesf_edge_filter.sv
hdl/qesf_ring.sv
hdl/quadrature_edge_sampler_fifo.sv
dv/quadrature_edge_sampler_fifo_checker.sv
dv/quadrature_edge_sampler_fifo_tb.sv
